/* rtl/dqls_pkg.sv */
// Shared constants and types for the deque with linear search.
package dqls_pkg;

    localparam int DQLS_DEPTH_DEF      = 16;
    localparam int DQLS_DATA_WIDTH_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FIELD5_W = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND       = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [FIELD5_W-1:0] length;
        logic [FIELD5_W-1:0] position;
        logic [STATUS_W-1:0] status;
    } dqls_res_t;

endpackage

/* rtl/deque_with_linear_search.sv */
// Bounded deque with front-to-back search over a ring memory.
// Push/pop: result registered on acceptance; one per cycle while m_tready allows.
// Find: reads the ring memory from the front through its one read port, stopping
//   at the first match or after the last entry; blocks new commands while scanning.
// Reset (aresetn low, synchronous) empties the queue; no clearing pass,
//   memory contents stay as they are and are only read once written.
module deque_with_linear_search #(
    parameter int DEPTH      = dqls_pkg::DQLS_DEPTH_DEF,
    parameter int DATA_WIDTH = dqls_pkg::DQLS_DATA_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cmd[2:0], value[34:3], zero pad [39:35]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[1:0], position[6:2], length[11:7], pad
);
    import dqls_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic                  out_valid_reg, out_valid_next;
    dqls_res_t             out_res_reg;
    logic                  out_free;
    logic                  res_valid;
    dqls_res_t             res;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr, rd_addr;
    logic [DATA_WIDTH-1:0] wr_data, rd_data;

    assign out_free = !out_valid_reg || m_tready;

    dqls_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (ADDR_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (s_tdata[CMD_W-1:0]),
        .value     (s_tdata[CMD_W+VALUE_W-1:CMD_W]),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    dqls_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result register: a new result only arrives when the slot is free
    always_comb begin
        if (res_valid) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_res_reg};

endmodule

/* rtl/dqls_ram.sv */
// Ring storage: one write port, one read port with registered read data.
module dqls_ram #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_W     = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/dqls_ctrl.sv */
// Command sequencer: front pointer, count, push/pop updates and the search scan.
module dqls_ctrl #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_W     = $clog2(DEPTH),
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  logic [dqls_pkg::CMD_W-1:0]   cmd,
    input  logic [dqls_pkg::VALUE_W-1:0] value,
    input  logic                         out_free,
    output logic                         res_valid,
    output dqls_pkg::dqls_res_t          res,
    output logic                         wr_en,
    output logic [ADDR_W-1:0]            wr_addr,
    output logic [DATA_WIDTH-1:0]        wr_data,
    output logic [ADDR_W-1:0]            rd_addr,
    input  logic [DATA_WIDTH-1:0]        rd_data
);
    import dqls_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(DEPTH);
    localparam logic [ADDR_W:0]   DEPTH_X  = (ADDR_W + 1)'(DEPTH);

    logic                  state_reg, state_next;
    logic [ADDR_W-1:0]     front_reg, front_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ADDR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0]     cmp_off_reg, cmp_off_next;
    logic [DATA_WIDTH-1:0] target_reg, target_next;

    logic                  accept;
    logic [63:0]           value_wide;
    logic [DATA_WIDTH-1:0] word;
    logic [ADDR_W-1:0]     front_inc, front_dec, rd_ptr_inc, back_idx;
    logic [ADDR_W:0]       back_sum;
    logic [CNT_W-1:0]      cmp_pos;

    function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] wrap_dec(input logic [ADDR_W-1:0] p);
        return (p == '0) ? LAST_IDX : p - 1'b1;
    endfunction

    assign cmd_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept     = cmd_valid && cmd_ready;
    assign value_wide = {32'd0, value};
    assign word       = value_wide[DATA_WIDTH-1:0];
    assign front_inc  = wrap_inc(front_reg);
    assign front_dec  = wrap_dec(front_reg);
    assign rd_ptr_inc = wrap_inc(rd_ptr_reg);
    // front + count stays below twice the depth when not full
    assign back_sum   = {1'b0, front_reg} + (ADDR_W + 1)'(count_reg);
    assign back_idx   = (back_sum >= DEPTH_X) ? ADDR_W'(back_sum - DEPTH_X)
                                              : ADDR_W'(back_sum);
    assign cmp_pos    = CNT_W'(cmp_off_reg) + 1'b1;

    always_comb begin
        state_next   = state_reg;
        front_next   = front_reg;
        count_next   = count_reg;
        rd_ptr_next  = rd_ptr_reg;
        cmp_off_next = cmp_off_reg;
        target_next  = target_reg;
        res_valid    = 1'b0;
        res.status   = STATUS_OK;
        res.position = '0;
        wr_en        = 1'b0;
        wr_addr      = back_idx;
        wr_data      = word;
        rd_addr      = (state_reg == ST_IDLE) ? front_reg : rd_ptr_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_valid = 1'b1;
                    unique case (cmd)
                        CMD_PUSH_FRONT: begin
                            if (count_reg == FULL_CNT) begin
                                res.status = STATUS_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = front_dec;
                                front_next = front_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (count_reg == FULL_CNT) begin
                                res.status = STATUS_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (count_reg == '0) begin
                                res.status = STATUS_EMPTY;
                            end else begin
                                front_next = front_inc;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_POP_BACK: begin
                            if (count_reg == '0) begin
                                res.status = STATUS_EMPTY;
                            end else begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_FIND: begin
                            if (count_reg == '0) begin
                                res.status = STATUS_EMPTY;
                            end else begin
                                // front entry read is issued this cycle
                                res_valid    = 1'b0;
                                target_next  = word;
                                rd_ptr_next  = front_inc;
                                cmp_off_next = '0;
                                state_next   = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // rd_data holds the entry at cmp_off; next read runs one ahead
                rd_ptr_next = rd_ptr_inc;
                if (rd_data == target_reg) begin
                    res_valid    = 1'b1;
                    res.status   = STATUS_OK;
                    res.position = FIELD5_W'(cmp_pos);
                    state_next   = ST_IDLE;
                end else if (cmp_pos == count_reg) begin
                    res_valid  = 1'b1;
                    res.status = STATUS_NOT_FOUND;
                    state_next = ST_IDLE;
                end else begin
                    cmp_off_next = cmp_off_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        res.length = FIELD5_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            front_reg <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg  <= rd_ptr_next;
        cmp_off_reg <= cmp_off_next;
        target_reg  <= target_next;
    end

endmodule

/* dv/tb_deque_with_linear_search.sv */
// Self-checking testbench for the deque with linear search: directed and random streams.
module tb_deque_with_linear_search;
    timeunit 1ns;
    timeprecision 1ps;

    import dqls_pkg::*;

    localparam int RING_DEPTH = DQLS_DEPTH_DEF;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int DRAIN_CYCLES = 2 * RING_DEPTH + 8;

    // command codes the block treats as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam logic [VALUE_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_ONES = 32'hFFFF_FFFF;

    class deque_scoreboard;
        logic [VALUE_W-1:0] ring [RING_DEPTH];
        int                 head;
        int                 fill;
        dqls_res_t          pending_res[$];
        int                 errors;
        int                 n_cmds;
        int                 n_checked;
        int                 n_full;
        int                 n_empty;
        int                 n_hit;
        int                 n_miss;

        function new();
            head = 0;
            fill = 0;
            errors = 0;
            n_cmds = 0;
            n_checked = 0;
            n_full = 0;
            n_empty = 0;
            n_hit = 0;
            n_miss = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        // Updates the deque image and queues the result this command must produce.
        function void note_command(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value);
            dqls_res_t r;
            r = '0;
            n_cmds++;
            case (cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                    if (fill >= RING_DEPTH) begin
                        r.status = STATUS_FULL;
                        n_full++;
                    end else if (cmd == CMD_PUSH_FRONT) begin
                        head = (head + RING_DEPTH - 1) % RING_DEPTH;
                        ring[head] = value;
                        fill++;
                    end else begin
                        ring[(head + fill) % RING_DEPTH] = value;
                        fill++;
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK: begin
                    if (fill == 0) begin
                        r.status = STATUS_EMPTY;
                        n_empty++;
                    end else begin
                        if (cmd == CMD_POP_FRONT)
                            head = (head + 1) % RING_DEPTH;
                        fill--;
                    end
                end
                CMD_FIND: begin
                    if (fill == 0) begin
                        r.status = STATUS_EMPTY;
                        n_empty++;
                    end else begin
                        r.status = STATUS_NOT_FOUND;
                        for (int k = 0; k < fill; k++) begin
                            if (ring[(head + k) % RING_DEPTH] === value) begin
                                r.status = STATUS_OK;
                                r.position = FIELD5_W'(k + 1);
                                break;
                            end
                        end
                        if (r.status == STATUS_OK)
                            n_hit++;
                        else
                            n_miss++;
                    end
                end
                default: ;
            endcase
            r.length = FIELD5_W'(fill);
            pending_res.push_back(r);
        endfunction

        task check_result(logic [15:0] tdata);
            dqls_res_t got;
            dqls_res_t want;
            got = dqls_res_t'(tdata[11:0]);
            if (pending_res.size() == 0) begin
                report($sformatf("unexpected result 0x%h", tdata));
            end else begin
                want = pending_res.pop_front();
                n_checked++;
                if (got.status !== want.status)
                    report($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.position !== want.position)
                    report($sformatf("position %0d, want %0d", got.position, want.position));
                if (got.length !== want.length)
                    report($sformatf("length %0d, want %0d", got.length, want.length));
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // cmd[2:0], value[34:3], zero pad [39:35]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // status[1:0], position[6:2], length[11:7], pad

    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    logic [VALUE_W-1:0] pushed_vals[$];

    deque_scoreboard sb = new();

    deque_with_linear_search DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    always @(negedge aclk) begin
        if (stall_pct == 0)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_command(s_tdata[2:0], s_tdata[34:3]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Entered and left at a falling edge; holds the transaction until accepted.
    task send(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, value, cmd};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (cmd <= CMD_FIND)
            items_sent++;
        if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK) begin
            pushed_vals.push_back(value);
            if (pushed_vals.size() > 24)
                void'(pushed_vals.pop_front());
        end
    endtask

    // Small pool of values gives duplicates, so first-match ordering gets exercised.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return VAL_ONES;
            3, 4: return VALUE_W'($urandom_range(0, 5));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_target();
        if (pushed_vals.size() != 0 && $urandom_range(0, 9) < 7)
            return pushed_vals[$urandom_range(0, pushed_vals.size() - 1)];
        return pick_value();
    endfunction

    task directed_seq();
        send(CMD_POP_FRONT, VAL_ONES);
        send(CMD_POP_BACK, '0);
        send(CMD_FIND, '0);
        send(CMD_SPARE_5, VAL_MIN);
        send(CMD_SPARE_6, VAL_MAX);
        send(CMD_SPARE_7, VAL_ONES);
        send(CMD_PUSH_BACK, VAL_MAX);
        send(CMD_PUSH_FRONT, VAL_MIN);
        send(CMD_PUSH_BACK, '0);
        send(CMD_PUSH_FRONT, VAL_ONES);
        send(CMD_FIND, VAL_ONES);      // hit at the front
        send(CMD_FIND, '0);            // hit at the back
        send(CMD_FIND, 32'h1234_5678); // no match
        send(CMD_SPARE_7, '0);
        send(CMD_POP_FRONT, '0);
        send(CMD_POP_BACK, '0);
        send(CMD_FIND, VAL_MAX);
    endtask

    task random_phase(int target);
        int n;
        int stop_at;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin    // run toward full, often past it
                    n = $urandom_range(4, 20);
                    repeat (n)
                        send($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                             pick_value());
                end
                3, 4: begin       // run toward empty, often past it
                    n = $urandom_range(4, 20);
                    repeat (n)
                        send($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK,
                             pick_value());
                end
                5, 6, 7: begin
                    n = $urandom_range(1, 6);
                    repeat (n)
                        send(CMD_FIND, pick_target());
                end
                default: begin    // noise, spare codes included
                    n = $urandom_range(2, 8);
                    repeat (n)
                        send(CMD_W'($urandom), $urandom);
                end
            endcase
        end
    endtask

    initial begin
        int idle_tab[4];
        int stall_tab[4];
        idle_tab  = '{0, 69, 0, 27};
        stall_tab = '{0, 0, 69, 27};
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        directed_seq();
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_tab[ph];
            stall_pct = stall_tab[ph];
            random_phase(ITEMS_PER_PHASE);
        end
        s_tvalid <= 1'b0;
        while (sb.pending_res.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Ran %0d commands (%0d valid), %0d results checked.",
                 sb.n_cmds, items_sent, sb.n_checked);
        $display("Full refusals %0d, empty hits %0d, finds matched %0d, missed %0d.",
                 sb.n_full, sb.n_empty, sb.n_hit, sb.n_miss);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout: stream stalled");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
rtl/dqls_pkg.sv
rtl/dqls_ram.sv
rtl/dqls_ctrl.sv
rtl/deque_with_linear_search.sv
dv/tb_deque_with_linear_search.sv
